// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/nncc_pkg.sv =====
// Package: widths, controller states and datapath operations.
`timescale 1ns / 1ps
`default_nettype none
package nncc_pkg;
    localparam int OPERAND_BITS = 31;
    localparam int OB           = OPERAND_BITS;
    localparam int CW           = OB + 2;          // signed Bezout coefficient
    localparam int DW           = 2 * OB;          // long dividend / product
    localparam int CNTW         = $clog2(DW + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHK, ST_ZWAIT, ST_GCD_TEST, ST_GCD_WAIT, ST_GCD_UPD,
        ST_XD_WAIT, ST_N_START, ST_N_WAIT, ST_CM_START, ST_CM_WAIT,
        ST_XR_START, ST_XR_WAIT, ST_MUL_CX, ST_R_START, ST_R_WAIT,
        ST_MUL_AR, ST_FIN, ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP, DP_LOAD, DP_RES_XZERO, DP_DIV_XZ, DP_RES_REMZ, DP_DIV_GCD,
        DP_GCD_MUL, DP_GCD_UPD, DP_DIV_XD, DP_RES_ZERO, DP_SET_XQ, DP_DIV_N,
        DP_SET_N, DP_DIV_CM, DP_SET_CM, DP_DIV_XR, DP_SET_XR, DP_MUL_CX,
        DP_DIV_R, DP_SET_R0, DP_MUL_AR, DP_RES_CMP
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic rem_zero;
        logic div_busy;
        logic div_rem_zero;
    } t_status;
endpackage
`default_nettype wire

// ===== rtl/nncc_dp.sv =====
// Datapath: operand registers, Euclid coefficients, shared divider, multipliers.
`timescale 1ns / 1ps
`default_nettype none
module nncc_dp import nncc_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [OB-1:0] i_target,
    input  wire logic [OB-1:0] i_step_one,
    input  wire logic [OB-1:0] i_step_two,
    input  wire t_cmd          i_cmd,
    output t_status            o_status,
    output logic               o_feasible
);
    logic [OB-1:0]        r_x, r_a, r_b, r_prev_rem, r_rem;
    logic signed [CW-1:0] r_prev_c, r_cur_c, r_prodc;
    logic [OB-1:0]        r_xq, r_n, r_cm, r_xr, r_r0;
    logic [DW-1:0]        r_prod;
    logic                 r_res;
    // divider
    logic [OB:0]          r_div_rem;
    logic [DW-1:0]        r_div_quo;
    logic [OB-1:0]        r_div_dvs;
    logic [CNTW-1:0]      r_div_cnt;
    logic                 r_div_run;

    logic [OB:0]            w_shift;
    logic                   w_ge;
    logic                   w_start;
    logic                   w_long;
    logic [OB-1:0]          w_dvd, w_dvs;
    logic signed [2*CW-1:0] w_mul_c;
    logic [CW-1:0]          w_abs_c;
    logic [OB-1:0]          w_q, w_r;

    assign w_q     = r_div_quo[OB-1:0];
    assign w_r     = r_div_rem[OB-1:0];
    assign w_shift = {r_div_rem[OB-1:0], r_div_quo[DW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div_dvs});
    assign w_mul_c = $signed({2'b00, r_div_quo[OB-1:0]}) * r_cur_c;
    assign w_abs_c = r_prev_c[CW-1] ? CW'(-r_prev_c) : CW'(r_prev_c);

    always_comb begin
        w_start = 1'b1;
        w_long  = 1'b0;
        w_dvd   = r_x;
        w_dvs   = r_b;
        case (i_cmd.op)
            DP_DIV_XZ:  w_dvs = (r_a == '0) ? r_b : r_a;
            DP_DIV_GCD: begin w_dvd = r_prev_rem; w_dvs = r_rem; end
            DP_DIV_XD:  w_dvs = r_prev_rem;
            DP_DIV_N:   begin w_dvd = r_b; w_dvs = r_prev_rem; end
            DP_DIV_CM:  begin w_dvd = w_abs_c[OB-1:0]; w_dvs = r_n; end
            DP_DIV_XR:  begin w_dvd = r_xq; w_dvs = r_n; end
            DP_DIV_R:   begin w_long = 1'b1; w_dvs = r_n; end
            default:    w_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_run <= 1'b0;
            r_div_cnt <= '0;
        end else if (w_start) begin
            r_div_run <= 1'b1;
            r_div_cnt <= w_long ? CNTW'(DW) : CNTW'(OB);
        end else if (r_div_run) begin
            r_div_cnt <= r_div_cnt - 1'b1;
            if (r_div_cnt == CNTW'(1)) r_div_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_div_rem <= '0;
            r_div_dvs <= w_dvs;
            r_div_quo <= w_long ? r_prod : {w_dvd, {OB{1'b0}}};
        end else if (r_div_run) begin
            r_div_rem <= w_ge ? (w_shift - {1'b0, r_div_dvs}) : w_shift;
            r_div_quo <= {r_div_quo[DW-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_x        <= i_target;
                r_a        <= i_step_one;
                r_b        <= i_step_two;
                r_prev_rem <= i_step_one;
                r_rem      <= i_step_two;
                r_prev_c   <= CW'(1);
                r_cur_c    <= '0;
            end
            DP_RES_XZERO: r_res <= (r_x == '0);
            DP_RES_REMZ:  r_res <= (w_r == '0);
            DP_RES_ZERO:  r_res <= 1'b0;
            DP_GCD_MUL:   r_prodc <= w_mul_c[CW-1:0];
            DP_GCD_UPD: begin
                r_prev_rem <= r_rem;
                r_rem      <= w_r;
                r_prev_c   <= r_cur_c;
                r_cur_c    <= r_prev_c - r_prodc;
            end
            DP_SET_XQ: r_xq <= w_q;
            DP_SET_N:  r_n  <= w_q;
            // shift a negative coefficient up into [0, n)
            DP_SET_CM: r_cm <= (r_prev_c[CW-1] && w_r != '0) ? (r_n - w_r) : w_r;
            DP_SET_XR: r_xr <= w_r;
            DP_MUL_CX: r_prod <= r_cm * r_xr;
            DP_SET_R0: r_r0 <= w_r;
            DP_MUL_AR: r_prod <= r_a * r_r0;
            DP_RES_CMP: r_res <= (r_prod <= {{OB{1'b0}}, r_x});
            default: ;
        endcase
    end

    assign o_status.a_zero       = (r_a == '0);
    assign o_status.b_zero       = (r_b == '0);
    assign o_status.rem_zero     = (r_rem == '0);
    assign o_status.div_busy     = r_div_run;
    assign o_status.div_rem_zero = (w_r == '0);
    assign o_feasible            = r_res;
endmodule
`default_nettype wire

// ===== rtl/nncc_ctrl.sv =====
// Controller: sequences Euclid iterations and the final scaling steps.
`timescale 1ns / 1ps
`default_nettype none
module nncc_ctrl import nncc_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_CHK;
            ST_CHK: begin
                if (i_status.a_zero && i_status.b_zero)      n_state = ST_DONE;
                else if (i_status.a_zero || i_status.b_zero) n_state = ST_ZWAIT;
                else                                         n_state = ST_GCD_TEST;
            end
            ST_ZWAIT:    if (!i_status.div_busy) n_state = ST_DONE;
            ST_GCD_TEST: n_state = i_status.rem_zero ? ST_XD_WAIT : ST_GCD_WAIT;
            ST_GCD_WAIT: if (!i_status.div_busy) n_state = ST_GCD_UPD;
            ST_GCD_UPD:  n_state = ST_GCD_TEST;
            ST_XD_WAIT: begin
                if (!i_status.div_busy)
                    n_state = i_status.div_rem_zero ? ST_N_START : ST_DONE;
            end
            ST_N_START:  n_state = ST_N_WAIT;
            ST_N_WAIT:   if (!i_status.div_busy) n_state = ST_CM_START;
            ST_CM_START: n_state = ST_CM_WAIT;
            ST_CM_WAIT:  if (!i_status.div_busy) n_state = ST_XR_START;
            ST_XR_START: n_state = ST_XR_WAIT;
            ST_XR_WAIT:  if (!i_status.div_busy) n_state = ST_MUL_CX;
            ST_MUL_CX:   n_state = ST_R_START;
            ST_R_START:  n_state = ST_R_WAIT;
            ST_R_WAIT:   if (!i_status.div_busy) n_state = ST_MUL_AR;
            ST_MUL_AR:   n_state = ST_FIN;
            ST_FIN:      n_state = ST_DONE;
            ST_DONE:     if (i_out_ready) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op    = DP_NOP;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = DP_LOAD;
            end
            ST_CHK: begin
                if (i_status.a_zero && i_status.b_zero)      o_cmd.op = DP_RES_XZERO;
                else if (i_status.a_zero || i_status.b_zero) o_cmd.op = DP_DIV_XZ;
            end
            ST_ZWAIT:    if (!i_status.div_busy) o_cmd.op = DP_RES_REMZ;
            ST_GCD_TEST: o_cmd.op = i_status.rem_zero ? DP_DIV_XD : DP_DIV_GCD;
            ST_GCD_WAIT: if (!i_status.div_busy) o_cmd.op = DP_GCD_MUL;
            ST_GCD_UPD:  o_cmd.op = DP_GCD_UPD;
            ST_XD_WAIT: begin
                if (!i_status.div_busy)
                    o_cmd.op = i_status.div_rem_zero ? DP_SET_XQ : DP_RES_ZERO;
            end
            ST_N_START:  o_cmd.op = DP_DIV_N;
            ST_N_WAIT:   if (!i_status.div_busy) o_cmd.op = DP_SET_N;
            ST_CM_START: o_cmd.op = DP_DIV_CM;
            ST_CM_WAIT:  if (!i_status.div_busy) o_cmd.op = DP_SET_CM;
            ST_XR_START: o_cmd.op = DP_DIV_XR;
            ST_XR_WAIT:  if (!i_status.div_busy) o_cmd.op = DP_SET_XR;
            ST_MUL_CX:   o_cmd.op = DP_MUL_CX;
            ST_R_START:  o_cmd.op = DP_DIV_R;
            ST_R_WAIT:   if (!i_status.div_busy) o_cmd.op = DP_SET_R0;
            ST_MUL_AR:   o_cmd.op = DP_MUL_AR;
            ST_FIN:      o_cmd.op = DP_RES_CMP;
            ST_DONE:     o_out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/nonneg_combination_check_core.sv =====
// Top level: decides whether target = a*r + b*s with r, s >= 0.
`timescale 1ns / 1ps
`default_nettype none
// One item at a time. An extended Euclid loop runs on a shared restoring
// divider that retires one quotient bit per cycle, and gcd of 31-bit values
// needs at most about 45 iterations. Four 31-bit divisions and one 62-bit
// division then scale the Bezout coefficient. The result is held until it is
// taken; the input is ready only while the block is idle.
module nonneg_combination_check_core import nncc_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [OB-1:0] i_target,
    input  wire logic [OB-1:0] i_step_one,
    input  wire logic [OB-1:0] i_step_two,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic               o_feasible
);
    t_cmd    w_cmd;
    t_status w_status;

    nncc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    nncc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_target   (i_target),
        .i_step_one (i_step_one),
        .i_step_two (i_step_two),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_feasible (o_feasible)
    );
endmodule
`default_nettype wire

// ===== rtl/nncc_checker.sv =====
// Port-level checker for the top level, attached by bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module nncc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_ready,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire logic o_feasible
);
    // a pending result blocks new input beats
    `ASSERT_NOW(a_busy_out, i_clk, i_rst_n, o_valid, !o_ready)
    // an accepted beat makes the block busy with no result yet
    `ASSERT_NEXT(a_busy_in, i_clk, i_rst_n, i_valid && o_ready, !o_ready && !o_valid)
    `ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_feasible))
endmodule

bind nonneg_combination_check_core nncc_checker u_nncc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_feasible (o_feasible)
);
`default_nettype wire

// ===== dv/nonneg_combination_check_core_checker.sv =====
// Checker: predicts feasibility of each accepted beat and compares results.
`timescale 1ns / 1ps
`default_nettype none
module nonneg_combination_check_core_checker import nncc_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_ready,
    input  wire logic [OB-1:0] i_target,
    input  wire logic [OB-1:0] i_step_one,
    input  wire logic [OB-1:0] i_step_two,
    input  wire logic          i_res_valid,
    input  wire logic          i_res_ready,
    input  wire logic          i_feasible,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results_seen
);
    bit expected_feasible_q[$];

    // Solve x = a*r + b*s over non-negative integers.
    function automatic bit predict_feasible(logic [OB-1:0] x_in, logic [OB-1:0] a_in,
                                            logic [OB-1:0] b_in);
        longint unsigned x, a, b, prev_rem, rem, q, nr, d, n, cm, r0;
        longint prev_c, cur_c, nc, sc;
        x = x_in;
        a = a_in;
        b = b_in;
        if (a == 0 && b == 0) return x == 0;
        if (a == 0) return (x % b) == 0;
        if (b == 0) return (x % a) == 0;
        prev_rem = a;
        rem = b;
        prev_c = 1;
        cur_c = 0;
        for (int i = 0; i < 96 && rem != 0; i++) begin
            q = prev_rem / rem;
            nr = prev_rem - q * rem;
            nc = prev_c - longint'(q) * cur_c;
            prev_rem = rem;
            rem = nr;
            prev_c = cur_c;
            cur_c = nc;
        end
        d = prev_rem;
        if (d == 0 || (x % d) != 0) return 1'b0;
        n = b / d;
        sc = prev_c % longint'(n);
        if (sc < 0) sc += longint'(n);
        cm = longint'(sc);
        r0 = (cm * ((x / d) % n)) % n;
        return (a * r0) <= x;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_results_seen <= 0;
            o_pending <= 0;
        end else begin
            if (i_valid && i_ready)
                expected_feasible_q.push_back(predict_feasible(i_target, i_step_one,
                                                               i_step_two));
            if (i_res_valid && i_res_ready) begin
                o_results_seen <= o_results_seen + 1;
                if (expected_feasible_q.size() == 0) begin
                    $error("feasible: unexpected result beat, actual %0b", i_feasible);
                    o_fail_count <= o_fail_count + 1;
                end else if (i_feasible !== expected_feasible_q[0]) begin
                    $error("feasible: expected %0b actual %0b", expected_feasible_q[0],
                           i_feasible);
                    o_fail_count <= o_fail_count + 1;
                    void'(expected_feasible_q.pop_front());
                end else begin
                    void'(expected_feasible_q.pop_front());
                end
            end
            o_pending <= expected_feasible_q.size();
        end
    end
endmodule
`default_nettype wire

// ===== dv/nonneg_combination_check_core_test.sv =====
// Testbench top: drives operand beats with random gaps and stalls, gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module nonneg_combination_check_core_test import nncc_pkg::*;;

    localparam int RAND_ITEMS = 280;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    logic [OB-1:0] i_target = '0;
    logic [OB-1:0] i_step_one = '0;
    logic [OB-1:0] i_step_two = '0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    logic          o_feasible;
    int            fail_count;
    int            pending;
    int            results_seen;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            items_sent = 0;

    always #2 i_clk = ~i_clk;

    nonneg_combination_check_core DUT (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_target, .i_step_one, .i_step_two,
        .o_valid, .i_ready, .o_feasible
    );

    nonneg_combination_check_core_checker checker_inst (
        .i_clk, .i_rst_n, .i_valid, .i_ready(o_ready), .i_target, .i_step_one,
        .i_step_two, .i_res_valid(o_valid), .i_res_ready(i_ready),
        .i_feasible(o_feasible), .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen)
    );

    // Result side: stall at the current rate.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Send one beat; idle first at the current rate. Valid stays up after the
    // accepting edge unless the next beat idles.
    task automatic send_beat(logic [OB-1:0] x, logic [OB-1:0] a, logic [OB-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_target <= x;
        i_step_one <= a;
        i_step_two <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic logic [OB-1:0] rand_operand();
        case ($urandom_range(4))
            0: return OB'($urandom_range(1, 20));
            1: return OB'($urandom_range(1, 1000));
            2: return OB'(1) << $urandom_range(OB - 1);
            3: return {OB{1'b1}} >> $urandom_range(OB - 1);
            default: return OB'($urandom);
        endcase
    endfunction

    initial begin
        logic [OB-1:0] a, b, x, g;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Extremes, zero steps, zero target.
        send_beat('0, OB'(1), OB'(1));
        send_beat('1, OB'(1), OB'(1));
        send_beat('1, '1, '1);
        send_beat('0, '1, '1);
        send_beat('0, '0, '0);
        send_beat(OB'(5), '0, '0);
        send_beat(OB'(12), '0, OB'(4));
        send_beat(OB'(13), '0, OB'(4));
        send_beat(OB'(12), OB'(3), '0);
        send_beat(OB'(14), OB'(3), '0);
        send_beat(OB'(1), OB'(2), OB'(4));
        send_beat(OB'(6), OB'(4), OB'(6));
        send_beat(OB'(2), OB'(4), OB'(6));
        send_beat(OB'(11), OB'(3), OB'(5));
        send_beat(OB'(7), OB'(3), OB'(5));
        send_beat(OB'(8), OB'(3), OB'(5));
        send_beat('1, '1, {OB{1'b1}} - OB'(1));
        send_beat({OB{1'b1}} - OB'(1), 31'h55555555, 31'h2aaaaaaa);
        send_beat(31'd1836311903, 31'd1134903170, 31'd701408733);
        send_beat('1, 31'd1836311903, 31'd1134903170);
        for (int i = 0; i < RAND_ITEMS; i++) begin
            case (i / (RAND_ITEMS / 4))
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 52; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 52; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            a = rand_operand();
            b = rand_operand();
            if ($urandom_range(9) == 0) a = '0;
            if ($urandom_range(9) == 0) b = '0;
            // Targets: random, a multiple of a small factor, a + b plus a small offset, or small.
            g = OB'($urandom_range(1, 6));
            case ($urandom_range(3))
                0: x = OB'($urandom);
                1: x = OB'($urandom_range(0, 2000)) * g;
                2: x = a + b + OB'($urandom_range(0, 50));
                default: x = OB'($urandom_range(0, 60));
            endcase
            send_beat(x, a, b);
        end
        i_valid <= 1'b0;
        while (results_seen < items_sent) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Covered %0d operand beats, %0d results, over four idle/stall phases.",
                 items_sent, results_seen);
        if (fail_count == 0 && pending == 0 && results_seen == items_sent)
            $display("nonneg_combination_check_core: match");
        else
            $display("nonneg_combination_check_core: mismatch");
        $finish;
    end

    initial begin
        #20000000;
        $display("nonneg_combination_check_core: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/nncc_pkg.sv
rtl/nncc_dp.sv
rtl/nncc_ctrl.sv
rtl/nonneg_combination_check_core.sv
rtl/nncc_checker.sv
dv/nonneg_combination_check_core_checker.sv
dv/nonneg_combination_check_core_test.sv
